// ===== hw/rtl/tgss_pkg.sv =====
// Package for the tilt gravity sand step block: shared constants.
// No dependencies; used by tilt_gravity_sand_step_top.
package tgss_pkg;

  // Default grid geometry and grain count
  localparam int GridWDef   = 64;
  localparam int GridHDef   = 32;
  localparam int GrainsDef  = 110;

  // Reset value of the tilt threshold (0.15^2 in Q8.24)
  localparam logic [31:0] MinTiltSqRst = 32'd377487;

  // Request opcodes
  localparam logic OpPile = 1'b0;
  localparam logic OpTick = 1'b1;

endpackage

// ===== hw/rtl/tilt_gravity_sand_step_top.sv =====
// Tilt-driven falling sand: occupancy and grain memories, gravity and a sequencer.
// Depends on tgss_pkg (constants).
//
// Channel | Direction | Content
// in_     | input     | tdata {accel_y, accel_x}, tuser {accel_valid, opcode}
// out_    | output    | tdata {row_bits, row_index}, tlast = last_row
// cfg_    | input     | min_tilt_sq write, 32 bits
//
// Each request is worked on alone. A pile request sweeps both memories for a fresh pile.
// A tick runs gravity work in S_G1, S_G2 and S_G3, then per grain and pass reads the
// grain record (dead grains too), reads the target row of each in-grid candidate, skips
// each off-grid one, and reads and rewrites the old row when the grain changes row.
// The row dump reads, loads and then holds each row until out_tready.
// After reset a clearing pass over both memories runs before in_tready rises.
module tilt_gravity_sand_step_top #(
  parameter int GRID_W = tgss_pkg::GridWDef,
  parameter int GRID_H = tgss_pkg::GridHDef,
  parameter int GRAINS = tgss_pkg::GrainsDef,
  localparam int ROW_W = $clog2(GRID_H),
  localparam int OUT_W = ((ROW_W + GRID_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // [15:0] accel_x, [31:16] accel_y
  input  logic [1:0]       in_tuser,   // [0] opcode, [1] accel_valid
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // row_index, then row_bits, zero pad
  output logic             out_tlast,  // last_row
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata
);

  localparam int COL_W  = $clog2(GRID_W);
  localparam int GA_W   = (GRAINS > 1) ? $clog2(GRAINS) : 1;
  localparam int GE_W   = 1 + ROW_W + COL_W;
  localparam int FILL_N = (GRAINS > GRID_H) ? GRAINS : GRID_H;
  localparam int FC_W   = $clog2(FILL_N + 1);
  localparam int RM_W   = $clog2(GRAINS + 1);
  localparam int X0     = GRID_W / 6;
  localparam int XMAX   = GRID_W - GRID_W / 6;
  localparam int SPAN   = XMAX - X0;
  localparam int CW     = (RM_W > COL_W + 1) ? RM_W : COL_W + 1;
  localparam int PAD_W  = OUT_W - ROW_W - GRID_W;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FILL = 4'd2;
  localparam logic [3:0] S_G1   = 4'd3;
  localparam logic [3:0] S_G2   = 4'd4;
  localparam logic [3:0] S_G3   = 4'd5;
  localparam logic [3:0] S_GRD  = 4'd6;
  localparam logic [3:0] S_GLAT = 4'd7;
  localparam logic [3:0] S_CAND = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_ORD  = 4'd10;
  localparam logic [3:0] S_OCLR = 4'd11;
  localparam logic [3:0] S_DRD  = 4'd12;
  localparam logic [3:0] S_DLD  = 4'd13;
  localparam logic [3:0] S_DOUT = 4'd14;

  // Memories
  logic [GRID_W-1:0] occ_mem [GRID_H];
  logic [GE_W-1:0]   grn_mem [GRAINS];
  logic [GRID_W-1:0] occ_q, occ_wd;
  logic [ROW_W-1:0]  occ_ra, occ_wa;
  logic              occ_we;
  logic [GE_W-1:0]   grn_q, grn_wd;
  logic [GA_W-1:0]   grn_ra, grn_wa;
  logic              grn_we;

  // Control and data registers
  logic [3:0]         state_r, state_nxt;
  logic [31:0]        thr_r;
  logic               fmode_r, fmode_nxt;
  logic [FC_W-1:0]    fcnt_r, fcnt_nxt;
  logic [RM_W-1:0]    rem_r, rem_nxt;
  logic [COL_W-1:0]   pc_r, pc_nxt;
  logic [ROW_W-1:0]   pr_r, pr_nxt;
  logic               pok_r, pok_nxt;
  logic signed [15:0] ax_in_r, ay_in_r;
  logic               av_r;
  logic [31:0]        sqx_r, sqy_r;
  logic signed [15:0] gx_r, gy_r;
  logic signed [1:0]  dx_r, dy_r, sx_r, sy_r;
  logic [GA_W-1:0]    gi_r, gi_nxt;
  logic               pass_r, pass_nxt;
  logic [COL_W-1:0]   gx_pos_r, gx_pos_nxt;
  logic [ROW_W-1:0]   gy_pos_r, gy_pos_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [COL_W-1:0]   tx_r, tx_nxt;
  logic [ROW_W-1:0]   ty_r, ty_nxt;
  logic [ROW_W-1:0]   dr_r, dr_nxt;
  logic [GRID_W-1:0]  obits_r;
  logic [ROW_W-1:0]   oidx_r;
  logic               olast_r;

  // Occupancy memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_q <= occ_mem[occ_ra];
  end

  // Grain memory: {alive, row, col}
  always_ff @(posedge clk) begin
    if (grn_we) begin
      grn_mem[grn_wa] <= grn_wd;
    end
    grn_q <= grn_mem[grn_ra];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tgss_pkg::MinTiltSqRst;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Gravity arithmetic: mapped sample, squares, quantized steps
  logic signed [16:0] mx_w;
  logic signed [15:0] mxs_w;
  logic [15:0]        abx_w, aby_w;
  logic [20:0]        tw_a_w, tw_b_w;
  logic [32:0]        mag_w;
  always_comb begin
    mx_w   = -{ay_in_r[15], ay_in_r};
    mxs_w  = (mx_w > 17'sd32767) ? 16'sd32767 : mx_w[15:0];
    mag_w  = {1'b0, sqx_r} + {1'b0, sqy_r};
    abx_w  = gx_r[15] ? 16'(-gx_r) : 16'(gx_r);
    aby_w  = gy_r[15] ? 16'(-gy_r) : 16'(gy_r);
    tw_a_w = 21'(aby_w) * 21'd20;
    tw_b_w = 21'(abx_w) * 21'd7;
  end

  // Note: the mapped y part is the raw accel_x sample
  logic signed [15:0] ay_in_r_x;
  assign ay_in_r_x = ax_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r <= '0;
      gy_r <= 16'sd1;
    end else if (state_r == S_G2 && av_r && mag_w >= {1'b0, thr_r}) begin
      gx_r <= mxs_w;
      gy_r <= ay_in_r_x;
    end
  end

  // Squares and quantized steps
  always_ff @(posedge clk) begin
    if (state_r == S_G1) begin
      sqx_r <= 32'(mxs_w * mxs_w);
      sqy_r <= 32'(ax_in_r * ax_in_r);
    end
    if (state_r == S_G3) begin
      if (abx_w >= aby_w) begin
        dx_r <= gx_r[15] ? 2'sb11 : 2'sb01;
        dy_r <= (tw_a_w > tw_b_w) ? (gy_r[15] ? 2'sb11 : 2'sb01) : 2'sb00;
        sx_r <= gx_r[15] ? 2'sb11 : 2'sb01;
        sy_r <= gy_r[15] ? 2'sb11 : 2'sb01;
      end else begin
        dy_r <= gy_r[15] ? 2'sb11 : 2'sb01;
        dx_r <= (21'(abx_w) * 21'd20 > 21'(aby_w) * 21'd7) ?
                (gx_r[15] ? 2'sb11 : 2'sb01) : 2'sb00;
        sy_r <= gy_r[15] ? 2'sb11 : 2'sb01;
        sx_r <= gx_r[15] ? 2'sb11 : 2'sb01;
      end
    end
  end

  // Candidate step for the current try
  logic signed [1:0]       cx_w, cy_w;
  logic signed [COL_W+1:0] tcx_w;
  logic signed [ROW_W+1:0] tcy_w;
  logic                    inb_w;
  always_comb begin
    case (k_r)
      3'd0: begin cx_w = dx_r;  cy_w = dy_r;  end
      3'd1: begin cx_w = sx_r;  cy_w = sy_r;  end
      3'd2: begin cx_w = sx_r;  cy_w = dy_r;  end
      3'd3: begin cx_w = dx_r;  cy_w = sy_r;  end
      3'd4: begin cx_w = -sx_r; cy_w = dy_r;  end
      default: begin cx_w = dx_r; cy_w = -sy_r; end
    endcase
    tcx_w = $signed({2'b00, gx_pos_r}) + (COL_W + 2)'(cx_w);
    tcy_w = $signed({2'b00, gy_pos_r}) + (ROW_W + 2)'(cy_w);
    inb_w = !tcx_w[COL_W+1] && !tcy_w[ROW_W+1] &&
            (tcx_w < (COL_W + 2)'(GRID_W)) && (tcy_w < (ROW_W + 2)'(GRID_H));
  end

  // Pile row mask
  logic [CW-1:0]     fn_w;
  logic [GRID_W-1:0] pmask_w;
  always_comb begin
    fn_w    = (CW'(rem_r) < CW'(SPAN)) ? CW'(rem_r) : CW'(SPAN);
    pmask_w = ({GRID_W{1'b1}} >> (CW'(GRID_W) - fn_w)) << X0;
  end

  // Bit masks of the target and the vacated cell
  logic [GRID_W-1:0] tbit_w, obit_w;
  logic              last_grain_w;
  assign tbit_w = GRID_W'(1) << tx_r;
  assign obit_w = GRID_W'(1) << gx_pos_r;
  assign last_grain_w = (gi_r == GA_W'(GRAINS - 1));

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    fmode_nxt  = fmode_r;
    fcnt_nxt   = fcnt_r;
    rem_nxt    = rem_r;
    pc_nxt     = pc_r;
    pr_nxt     = pr_r;
    pok_nxt    = pok_r;
    gi_nxt     = gi_r;
    pass_nxt   = pass_r;
    gx_pos_nxt = gx_pos_r;
    gy_pos_nxt = gy_pos_r;
    k_nxt      = k_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    dr_nxt     = dr_r;
    occ_ra     = dr_r;
    occ_wa     = '0;
    occ_wd     = '0;
    occ_we     = 1'b0;
    grn_ra     = gi_r;
    grn_wa     = fcnt_r[GA_W-1:0];
    grn_wd     = '0;
    grn_we     = 1'b0;
    case (state_r)
      S_INIT, S_FILL: begin
        // Sweep both memories: zeros after reset, a fresh pile on request
        if (fcnt_r < FC_W'(GRAINS)) begin
          grn_we = 1'b1;
          grn_wd = (fmode_r && pok_r) ? {1'b1, pr_r, pc_r} : '0;
          if (pc_r == COL_W'(XMAX - 1)) begin
            pc_nxt = COL_W'(X0);
            if (pr_r == '0) begin
              pok_nxt = 1'b0;
            end else begin
              pr_nxt = pr_r - 1'b1;
            end
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        if (fcnt_r < FC_W'(GRID_H)) begin
          occ_we = 1'b1;
          occ_wa = ROW_W'(GRID_H - 1) - fcnt_r[ROW_W-1:0];
          if (fmode_r && fcnt_r != '0) begin
            occ_wd  = pmask_w;
            rem_nxt = rem_r - RM_W'(fn_w);
          end
        end
        fcnt_nxt = fcnt_r + 1'b1;
        if (fcnt_r == FC_W'(FILL_N - 1)) begin
          state_nxt = fmode_r ? S_DRD : S_IDLE;
          dr_nxt    = '0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          fcnt_nxt = '0;
          rem_nxt  = RM_W'(GRAINS);
          pc_nxt   = COL_W'(X0);
          pr_nxt   = ROW_W'(GRID_H - 2);
          pok_nxt  = 1'b1;
          fmode_nxt = 1'b1;
          gi_nxt   = '0;
          pass_nxt = 1'b0;
          state_nxt = (in_tuser[0] == tgss_pkg::OpTick) ? S_G1 : S_FILL;
        end
      end
      S_G1: state_nxt = S_G2;
      S_G2: state_nxt = S_G3;
      S_G3: state_nxt = S_GRD;
      S_GRD: begin
        // Fetch the grain record
        state_nxt = S_GLAT;
      end
      S_GLAT: begin
        gx_pos_nxt = grn_q[COL_W-1:0];
        gy_pos_nxt = grn_q[ROW_W+COL_W-1:COL_W];
        k_nxt      = '0;
        state_nxt  = grn_q[GE_W-1] ? S_CAND : S_GRD;
        if (!grn_q[GE_W-1]) begin
          gi_nxt = last_grain_w ? '0 : gi_r + 1'b1;
          if (last_grain_w) begin
            pass_nxt  = 1'b1;
            state_nxt = pass_r ? S_DRD : S_GRD;
            dr_nxt    = '0;
          end
        end
      end
      S_CAND: begin
        // Issue a read of the target row, or skip an off-grid candidate
        tx_nxt = tcx_w[COL_W-1:0];
        ty_nxt = tcy_w[ROW_W-1:0];
        occ_ra = tcy_w[ROW_W-1:0];
        if (inb_w) begin
          state_nxt = S_CHK;
        end else if (k_r == 3'd5) begin
          gi_nxt = last_grain_w ? '0 : gi_r + 1'b1;
          state_nxt = S_GRD;
          if (last_grain_w) begin
            pass_nxt  = 1'b1;
            state_nxt = pass_r ? S_DRD : S_GRD;
            dr_nxt    = '0;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_CHK: begin
        if ((occ_q & tbit_w) == '0) begin
          // Move: set the target, clear the old cell now or in the next row access
          occ_we = 1'b1;
          occ_wa = ty_r;
          occ_wd = (ty_r == gy_pos_r) ? ((occ_q & ~obit_w) | tbit_w) : (occ_q | tbit_w);
          grn_we = 1'b1;
          grn_wa = gi_r;
          grn_wd = {1'b1, ty_r, tx_r};
          if (ty_r != gy_pos_r) begin
            state_nxt = S_ORD;
          end else begin
            gi_nxt = last_grain_w ? '0 : gi_r + 1'b1;
            state_nxt = S_GRD;
            if (last_grain_w) begin
              pass_nxt  = 1'b1;
              state_nxt = pass_r ? S_DRD : S_GRD;
              dr_nxt    = '0;
            end
          end
        end else if (k_r == 3'd5) begin
          gi_nxt = last_grain_w ? '0 : gi_r + 1'b1;
          state_nxt = S_GRD;
          if (last_grain_w) begin
            pass_nxt  = 1'b1;
            state_nxt = pass_r ? S_DRD : S_GRD;
            dr_nxt    = '0;
          end
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_CAND;
        end
      end
      S_ORD: begin
        occ_ra = gy_pos_r;
        state_nxt = S_OCLR;
      end
      S_OCLR: begin
        occ_we = 1'b1;
        occ_wa = gy_pos_r;
        occ_wd = occ_q & ~obit_w;
        gi_nxt = last_grain_w ? '0 : gi_r + 1'b1;
        state_nxt = S_GRD;
        if (last_grain_w) begin
          pass_nxt  = 1'b1;
          state_nxt = pass_r ? S_DRD : S_GRD;
          dr_nxt    = '0;
        end
      end
      S_DRD: state_nxt = S_DLD;
      S_DLD: state_nxt = S_DOUT;
      S_DOUT: begin
        // Hold the row until taken
        if (out_tready) begin
          dr_nxt    = dr_r + 1'b1;
          state_nxt = (dr_r == ROW_W'(GRID_H - 1)) ? S_IDLE : S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fmode_r <= 1'b0;
      fcnt_r  <= '0;
      pok_r   <= 1'b0;
      gi_r    <= '0;
      pass_r  <= 1'b0;
      k_r     <= '0;
      dr_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fmode_r <= fmode_nxt;
      fcnt_r  <= fcnt_nxt;
      pok_r   <= pok_nxt;
      gi_r    <= gi_nxt;
      pass_r  <= pass_nxt;
      k_r     <= k_nxt;
      dr_r    <= dr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    pc_r     <= pc_nxt;
    pr_r     <= pr_nxt;
    gx_pos_r <= gx_pos_nxt;
    gy_pos_r <= gy_pos_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
    if (in_tvalid && in_tready) begin
      ax_in_r <= in_tdata[15:0];
      ay_in_r <= in_tdata[31:16];
      av_r    <= in_tuser[1];
    end
    if (state_r == S_DLD) begin
      obits_r <= occ_q;
      oidx_r  <= dr_r;
      olast_r <= (dr_r == ROW_W'(GRID_H - 1));
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DOUT);
  assign out_tdata  = {{PAD_W{1'b0}}, obits_r, oidx_r};
  assign out_tlast  = olast_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a row is pending");
  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_G1 || state_r == S_FILL))
    else $error("request did not start work");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("dump did not return to idle");
  a_move_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (tx_r < COL_W'(GRID_W - 1) || tx_r == COL_W'(GRID_W - 1)))
    else $error("target column off grid");

endmodule
